@@ hdl/gb5_pkg.sv @@
// ---------------------------------------------------------------------------
// gb5_pkg: shared definitions for the 5x5 gaussian blur
// Kernel geometry, line memory layout, register indexes and tap weight map.
// ---------------------------------------------------------------------------
package gb5_pkg;

	localparam int KERNEL     = 5;
	localparam int HALF       = KERNEL / 2;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 2048;

	// line memory: one word holds two adjacent columns of the 8-row ring
	localparam int RING_ROWS  = 8;
	localparam int LANES      = 2 * RING_ROWS;
	localparam int MEM_DEPTH  = MAX_WIDTH / 2;
	localparam int MEM_AW     = $clog2(MEM_DEPTH);
	localparam int LANE_W     = $clog2(LANES);
	localparam int RING_W     = $clog2(RING_ROWS);

	// result queue behind the arithmetic pipeline
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int NUM_WEIGHTS = 6;

	typedef logic [LANES-1:0][7:0] mem_word_t;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_WEIGHT_D0    = 3'd2,
		REG_WEIGHT_D1    = 3'd3,
		REG_WEIGHT_D2    = 3'd4,
		REG_WEIGHT_D4    = 3'd5,
		REG_WEIGHT_D5    = 3'd6,
		REG_WEIGHT_D8    = 3'd7
	} reg_idx_t;

	// weight slot for a tap, chosen by squared distance from the centre
	function automatic int weight_slot(input int ky, input int kx);
		int dy;
		int dx;
		int d;
		dy = ky - HALF;
		dx = kx - HALF;
		d  = dy * dy + dx * dx;
		case (d)
			0:       weight_slot = 0;
			1:       weight_slot = 1;
			2:       weight_slot = 2;
			4:       weight_slot = 3;
			5:       weight_slot = 4;
			default: weight_slot = 5;
		endcase
	endfunction

endpackage

@@ hdl/gaussian_blur_5x5.sv @@
// ---------------------------------------------------------------------------
// gaussian_blur_5x5: streaming 5x5 gaussian blur of one 8-bit channel
// Line memory, sliding window, weighted sum and result queue.
// ---------------------------------------------------------------------------
// Usage:
// - pixels enter on s_ in raster order, one request per cycle while s_tready
//   is high; s_tuser set marks a drain request that carries no pixel and only
//   lets a pending result out (needed to flush the last two rows of a frame)
// - results leave on the m_ group in raster order; m_tlast marks the last
//   pixel of the frame, after which a new frame starts
// - each accepted request yields at most one result via the pipeline;
//   the block sustains one request per cycle while s_tready is high
// - the line memory is read at two words each cycle (the first column pair
//   and the column entering the window) and written once per pixel; the
//   window slides one column per result
// - an 8-entry result queue parts the sides; when the receiver stalls the
//   queue fills and s_tready drops once 8 results are queued or in flight
// - reset restores the default geometry and weights and starts a frame;
//   a write of width or height also restarts the frame
// - unchecked by the block: configuration is to be written only while idle
// ---------------------------------------------------------------------------
module gaussian_blur_5x5 import gb5_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// pixel requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel
	input  logic        s_tuser,   // [0] drain
	// blurred results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] blurred
	output logic        m_tlast,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [10:0] width_q;
	logic [11:0] height_q;
	logic [15:0] weight_q [NUM_WEIGHTS];

	// frame position counters
	logic [9:0]  in_col_q;
	logic [11:0] in_row_q;
	logic [9:0]  out_col_q;
	logic [11:0] out_row_q;

	logic [10:0] w_eff;
	logic [11:0] h_eff;

	logic        accept;
	logic        pix_take;
	logic [10:0] col_inc;
	logic [9:0]  in_col_nx;
	logic [11:0] in_row_nx;
	logic [12:0] need_r;
	logic [11:0] need_c;
	logic        emit;
	logic        last_out;
	logic [10:0] col_b;
	logic        col1_bit;
	logic [RING_W-1:0] lane_row [KERNEL];

	logic [3:0]  occ_q;
	logic        geom_write;

	// line memory
	mem_word_t   line_mem [MEM_DEPTH];

	// stage 1
	logic        v_s1;
	logic        first_s1;
	logic        last_s1;
	logic [RING_W-1:0] lane_s1 [KERNEL];
	logic        colb_bit_s1;
	logic        col1_bit_s1;
	logic [MEM_AW-1:0] addr_b_s1;
	mem_word_t   rd_a_s1;
	mem_word_t   rd_b_s1;
	logic        fwd_en_s1;
	logic [MEM_AW-1:0] fwd_addr_s1;
	logic [LANE_W-1:0] fwd_lane_s1;
	logic [7:0]  fwd_data_s1;
	mem_word_t   word_a;
	mem_word_t   word_b;

	// stage 2: window
	logic        v_s2;
	logic        last_s2;
	logic [7:0]  win_q [KERNEL][KERNEL];

	// stage 3: rounded products
	logic        v_s3;
	logic        last_s3;
	logic [7:0]  prod_s3 [KERNEL][KERNEL];

	// stage 4: row sums
	logic        v_s4;
	logic        last_s4;
	logic [10:0] rsum_s4 [KERNEL];
	logic [12:0] total;
	logic [7:0]  clamped;

	// result queue
	logic [8:0]  fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [3:0]  cnt_q;
	logic        pop;

	// effective geometry
	always_comb begin
		if (width_q == 11'd0)
			w_eff = 11'd1;
		else if (width_q > 11'(MAX_WIDTH))
			w_eff = 11'(MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == 12'd0)
			h_eff = 12'd1;
		else if (height_q > 12'(MAX_HEIGHT))
			h_eff = 12'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	assign s_tready   = (occ_q < 4'(FIFO_DEPTH));
	assign accept     = s_tvalid && s_tready;
	assign geom_write = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	// input position after the request's pixel
	always_comb begin
		pix_take  = accept && !s_tuser && (in_row_q < h_eff) && ({1'b0, in_col_q} < w_eff);
		col_inc   = {1'b0, in_col_q} + 11'd1;
		in_col_nx = in_col_q;
		in_row_nx = in_row_q;
		if (pix_take) begin
			if (col_inc >= w_eff) begin
				in_col_nx = '0;
				in_row_nx = in_row_q + 12'd1;
			end else begin
				in_col_nx = col_inc[9:0];
			end
		end
	end

	// readiness of the next output
	always_comb begin
		need_r = {1'b0, out_row_q} + 13'(HALF);
		if (need_r > {1'b0, h_eff} - 13'd1)
			need_r = {1'b0, h_eff} - 13'd1;
		need_c = {2'b0, out_col_q} + 12'(HALF);
		if (need_c > {1'b0, w_eff} - 12'd1)
			need_c = {1'b0, w_eff} - 12'd1;
		emit = accept && (({1'b0, in_row_nx} > need_r) ||
			({1'b0, in_row_nx} == need_r && {2'b0, in_col_nx} > need_c));
		last_out = (out_row_q == h_eff - 12'd1) && ({1'b0, out_col_q} == w_eff - 11'd1);
	end

	// columns and ring rows to fetch for the output
	always_comb begin
		logic signed [13:0] rr;
		col_b = {1'b0, out_col_q} + 11'(HALF);
		if (col_b > w_eff - 11'd1)
			col_b = w_eff - 11'd1;
		col1_bit = (w_eff > 11'd1);
		for (int ky = 0; ky < KERNEL; ky++) begin
			rr = $signed({2'b0, out_row_q}) + 14'(ky - HALF);
			if (rr < 0)
				rr = '0;
			else if (rr > $signed({2'b0, h_eff}) - 14'sd1)
				rr = $signed({2'b0, h_eff}) - 14'sd1;
			lane_row[ky] = rr[RING_W-1:0];
		end
	end

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 11'd1024;
			height_q    <= 12'd768;
			weight_q[0] <= 16'd10619;
			weight_q[1] <= 16'd6440;
			weight_q[2] <= 16'd3906;
			weight_q[3] <= 16'd1439;
			weight_q[4] <= 16'd873;
			weight_q[5] <= 16'd194;
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_IMAGE_WIDTH:  width_q     <= cfg_data[10:0];
					REG_IMAGE_HEIGHT: height_q    <= cfg_data[11:0];
					REG_WEIGHT_D0:    weight_q[0] <= cfg_data;
					REG_WEIGHT_D1:    weight_q[1] <= cfg_data;
					REG_WEIGHT_D2:    weight_q[2] <= cfg_data;
					REG_WEIGHT_D4:    weight_q[3] <= cfg_data;
					REG_WEIGHT_D5:    weight_q[4] <= cfg_data;
					REG_WEIGHT_D8:    weight_q[5] <= cfg_data;
					default: ;
				endcase
			end
			if (geom_write || (emit && last_out)) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= in_col_nx;
				in_row_q <= in_row_nx;
				if (emit) begin
					if ({1'b0, out_col_q} + 11'd1 >= w_eff) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 12'd1;
					end else begin
						out_col_q <= out_col_q + 10'd1;
					end
				end
			end
		end
	end

	// line memory write and column reads
	always_ff @(posedge clk) begin
		if (pix_take)
			line_mem[in_col_q[9:1]][{in_col_q[0], in_row_q[RING_W-1:0]}] <= s_tdata;
		rd_a_s1 <= line_mem[0];
		rd_b_s1 <= line_mem[col_b[9:1]];
	end

	// stage 1 request payload
	always_ff @(posedge clk) begin
		first_s1    <= (out_col_q == 10'd0);
		last_s1     <= last_out;
		lane_s1     <= lane_row;
		colb_bit_s1 <= col_b[0];
		col1_bit_s1 <= col1_bit;
		addr_b_s1   <= col_b[9:1];
		fwd_addr_s1 <= in_col_q[9:1];
		fwd_lane_s1 <= {in_col_q[0], in_row_q[RING_W-1:0]};
		fwd_data_s1 <= s_tdata;
	end

	// forward the pixel written in the same cycle as the read
	always_comb begin
		word_a = rd_a_s1;
		word_b = rd_b_s1;
		if (fwd_en_s1 && fwd_addr_s1 == '0)
			word_a[fwd_lane_s1] = fwd_data_s1;
		if (fwd_en_s1 && fwd_addr_s1 == addr_b_s1)
			word_b[fwd_lane_s1] = fwd_data_s1;
	end

	// window: load three columns at row start, else slide one column
	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		if (v_s1) begin
			for (int ky = 0; ky < KERNEL; ky++) begin
				if (first_s1) begin
					for (int kx = 0; kx < HALF + 1; kx++)
						win_q[ky][kx] <= word_a[{1'b0, lane_s1[ky]}];
					win_q[ky][HALF+1] <= word_a[{col1_bit_s1, lane_s1[ky]}];
				end else begin
					for (int kx = 0; kx < KERNEL - 1; kx++)
						win_q[ky][kx] <= win_q[ky][kx+1];
				end
				win_q[ky][KERNEL-1] <= word_b[{colb_bit_s1, lane_s1[ky]}];
			end
		end
	end

	// rounded tap products
	always_ff @(posedge clk) begin
		logic [23:0] p;
		last_s3 <= last_s2;
		for (int ky = 0; ky < KERNEL; ky++) begin
			for (int kx = 0; kx < KERNEL; kx++) begin
				p = 24'(win_q[ky][kx]) * 24'(weight_q[weight_slot(ky, kx)]) + 24'd32768;
				prod_s3[ky][kx] <= p[23:16];
			end
		end
	end

	// row sums
	always_ff @(posedge clk) begin
		logic [10:0] s;
		last_s4 <= last_s3;
		for (int ky = 0; ky < KERNEL; ky++) begin
			s = '0;
			for (int kx = 0; kx < KERNEL; kx++)
				s = s + 11'(prod_s3[ky][kx]);
			rsum_s4[ky] <= s;
		end
	end

	// total and clamp
	always_comb begin
		total = '0;
		for (int ky = 0; ky < KERNEL; ky++)
			total = total + 13'(rsum_s4[ky]);
		clamped = (total > 13'd255) ? 8'd255 : total[7:0];
	end

	// pipeline valids and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			fwd_en_s1 <= 1'b0;
			occ_q     <= '0;
		end else begin
			v_s1      <= emit;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			fwd_en_s1 <= pix_take;
			occ_q     <= occ_q + 4'(emit) - 4'(pop);
		end
	end

	// result queue
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 4'd0);
	assign m_tdata  = fifo_q[rd_ptr_q][7:0];
	assign m_tlast  = fifo_q[rd_ptr_q][8];

	always_ff @(posedge clk) begin
		if (v_s4)
			fifo_q[wr_ptr_q] <= {last_s4, clamped};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s4)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + 4'(v_s4) - 4'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	// queued results never exceed the outstanding count
	a_cnt_le_occ: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= occ_q)
		else $error("result queue holds more than outstanding requests");

	// outstanding results never exceed the queue depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 4'(FIFO_DEPTH))
		else $error("outstanding results exceed queue depth");

	// last output of a frame restarts all position counters
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_out) |=> (out_row_q == 12'd0 && out_col_q == 10'd0 &&
			in_row_q == 12'd0 && in_col_q == 10'd0))
		else $error("counters not cleared after last output");

	// every request that emits a result carries it through the pipeline to v_s4
	a_pipe_latency: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> ##4 v_s4)
		else $error("result lost in pipeline");
`endif

endmodule
